>>> hdl/sldiv_pkg.sv
// Package with payload types, element codes and per-item control types for the lane divider.
package sldiv_pkg;

    localparam int LaneW   = 64;

    typedef enum logic [2:0] {
        CMD_U16 = 3'd0,
        CMD_S16 = 3'd1,
        CMD_U32 = 3'd2,
        CMD_S32 = 3'd3,
        CMD_U64 = 3'd4,
        CMD_S64 = 3'd5
    } t_cmd;

    // Element width selection carried with each item.
    localparam logic [1:0] WSEL_16 = 2'd0;
    localparam logic [1:0] WSEL_32 = 2'd1;
    localparam logic [1:0] WSEL_64 = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] dividend_lo;
        logic [63:0] dividend_hi;
        logic [63:0] divisor_lo;
        logic [63:0] divisor_hi;
    } t_in;

    typedef struct packed {
        logic [63:0] quotient_lo;
        logic [63:0] quotient_hi;
        logic [63:0] remainder_lo;
        logic [63:0] remainder_hi;
    } t_out;

    // Per-item control that travels with the data through every stage.
    typedef struct packed {
        logic       bad;
        logic       sgn;
        logic [1:0] wsel;
    } t_ctl;

    // Per-element flags held for the final fix-up.
    typedef struct packed {
        logic [3:0] neg_q;
        logic [3:0] neg_r;
    } t_fix;

endpackage

>>> hdl/sldiv_lane.sv
// One 64-bit lane: prepares magnitudes, runs a pipelined restoring divider, applies signs and zero-divisor results.
module sldiv_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  sldiv_pkg::t_ctl       i_ctl,
    input  logic [63:0]           i_x,
    input  logic [63:0]           i_y,
    output logic [63:0]           o_q,
    output logic [63:0]           o_r
);

    localparam int NStg = sldiv_pkg::LaneW;

    // Packed-segment magnitudes: each 16-, 32- or 64-bit segment (per wsel) belongs to a sub-element.
    logic [63:0] ux, uy;
    sldiv_pkg::t_fix fix_in;

    function automatic logic [63:0] neg_seg(input logic [63:0] v, input logic [1:0] wsel,
                                            input logic [3:0] sel);
        logic [63:0] res;
        res = v;
        case (wsel)
            sldiv_pkg::WSEL_16: begin
                for (int k = 0; k < 4; k++)
                    if (sel[k]) res[16*k +: 16] = 16'(-v[16*k +: 16]);
            end
            sldiv_pkg::WSEL_32: begin
                for (int k = 0; k < 2; k++)
                    if (sel[2*k]) res[32*k +: 32] = 32'(-v[32*k +: 32]);
            end
            default: begin
                if (sel[0]) res = -v;
            end
        endcase
        return res;
    endfunction

    logic [3:0] nx, ny;
    always_comb begin
        nx = '0;
        ny = '0;
        case (i_ctl.wsel)
            sldiv_pkg::WSEL_16: begin
                for (int k = 0; k < 4; k++) begin
                    nx[k] = i_ctl.sgn & i_x[16*k+15];
                    ny[k] = i_ctl.sgn & i_y[16*k+15];
                end
            end
            sldiv_pkg::WSEL_32: begin
                for (int k = 0; k < 2; k++) begin
                    nx[2*k] = i_ctl.sgn & i_x[32*k+31];
                    ny[2*k] = i_ctl.sgn & i_y[32*k+31];
                end
            end
            default: begin
                nx[0] = i_ctl.sgn & i_x[63];
                ny[0] = i_ctl.sgn & i_y[63];
            end
        endcase
        ux = neg_seg(i_x, i_ctl.wsel, nx);
        uy = neg_seg(i_y, i_ctl.wsel, ny);
        fix_in.neg_q = nx ^ ny;
        fix_in.neg_r = nx;
    end

    // Stage registers: partial remainder per segment lives in r_rem, quotient bits shift into r_qx.
    logic [63:0]     r_rem [NStg+1];
    logic [63:0]     r_qx  [NStg+1];
    logic [63:0]     r_dv  [NStg+1];
    sldiv_pkg::t_ctl r_ctl [NStg+1];
    sldiv_pkg::t_fix r_fix [NStg+1];
    logic [63:0]     r_x   [NStg+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_qx[0]  <= ux;
            r_dv[0]  <= uy;
            r_ctl[0] <= i_ctl;
            r_fix[0] <= fix_in;
            r_x[0]   <= i_x;
        end
    end

    // Each stage below the element width does one restoring step on every segment; a segment
    // that spans several 16-bit slices uses the wider grouping selected by wsel.
    for (genvar s = 0; s < NStg; s++) begin : g_stg
        logic [63:0] n_rem, n_qx;
        always_comb begin
            n_rem = r_rem[s];
            n_qx  = r_qx[s];
            case (r_ctl[s].wsel)
                sldiv_pkg::WSEL_16: begin
                    for (int k = 0; k < 4; k++) begin
                        logic [16:0] t;
                        t = {r_rem[s][16*k +: 16], r_qx[s][16*k+15]};
                        if (s < 16 && t >= {1'b0, r_dv[s][16*k +: 16]}) begin
                            n_rem[16*k +: 16] = 16'(t - {1'b0, r_dv[s][16*k +: 16]});
                            n_qx[16*k +: 16]  = {r_qx[s][16*k +: 15], 1'b1};
                        end else if (s < 16) begin
                            n_rem[16*k +: 16] = t[15:0];
                            n_qx[16*k +: 16]  = {r_qx[s][16*k +: 15], 1'b0};
                        end
                    end
                end
                sldiv_pkg::WSEL_32: begin
                    for (int k = 0; k < 2; k++) begin
                        logic [32:0] t;
                        t = {r_rem[s][32*k +: 32], r_qx[s][32*k+31]};
                        if (s < 32 && t >= {1'b0, r_dv[s][32*k +: 32]}) begin
                            n_rem[32*k +: 32] = 32'(t - {1'b0, r_dv[s][32*k +: 32]});
                            n_qx[32*k +: 32]  = {r_qx[s][32*k +: 31], 1'b1};
                        end else if (s < 32) begin
                            n_rem[32*k +: 32] = t[31:0];
                            n_qx[32*k +: 32]  = {r_qx[s][32*k +: 31], 1'b0};
                        end
                    end
                end
                default: begin
                    logic [64:0] t;
                    t = {r_rem[s], r_qx[s][63]};
                    if (t >= {1'b0, r_dv[s]}) begin
                        n_rem = 64'(t - {1'b0, r_dv[s]});
                        n_qx  = {r_qx[s][62:0], 1'b1};
                    end else begin
                        n_rem = t[63:0];
                        n_qx  = {r_qx[s][62:0], 1'b0};
                    end
                end
            endcase
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_qx[s+1]  <= n_qx;
                r_dv[s+1]  <= r_dv[s];
                r_ctl[s+1] <= r_ctl[s];
                r_fix[s+1] <= r_fix[s];
                r_x[s+1]   <= r_x[s];
            end
        end
    end

    // Final signs; a zero divisor leaves an all-ones quotient and the dividend as remainder; a bad command gives zeros.
    logic [63:0] qf, rf;
    always_comb begin
        qf = neg_seg(r_qx[NStg], r_ctl[NStg].wsel, r_fix[NStg].neg_q);
        rf = neg_seg(r_rem[NStg], r_ctl[NStg].wsel, r_fix[NStg].neg_r);
        case (r_ctl[NStg].wsel)
            sldiv_pkg::WSEL_16: begin
                for (int k = 0; k < 4; k++)
                    if (r_dv[NStg][16*k +: 16] == '0) begin
                        qf[16*k +: 16] = '1;
                        rf[16*k +: 16] = r_x[NStg][16*k +: 16];
                    end
            end
            sldiv_pkg::WSEL_32: begin
                for (int k = 0; k < 2; k++)
                    if (r_dv[NStg][32*k +: 32] == '0) begin
                        qf[32*k +: 32] = '1;
                        rf[32*k +: 32] = r_x[NStg][32*k +: 32];
                    end
            end
            default: begin
                if (r_dv[NStg] == '0) begin
                    qf = '1;
                    rf = r_x[NStg];
                end
            end
        endcase
        if (r_ctl[NStg].bad) begin
            qf = '0;
            rf = '0;
        end
    end

    assign o_q = qf;
    assign o_r = rf;

    logic unused_ok;
    assign unused_ok = i_rst_n | i_valid;

endmodule

>>> hdl/simd_lane_integer_divider_unit.sv
// Top level of the packed-lane integer divider: two lane pipelines and the output merge.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | sldiv_pkg::t_in
//  out     | output    | o_valid / i_ready  | sldiv_pkg::t_out
//
// The result comes from the input register and the 64-stage restoring divider
// in each lane; one item is accepted every cycle while the output is not held.
// The whole pipeline advances together and stops when the output is held.
// Reset clears only the valid bits of the pipeline.
module simd_lane_integer_divider_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sldiv_pkg::t_in      i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sldiv_pkg::t_out     o_data
);

    localparam int Depth = sldiv_pkg::LaneW + 1;

    logic            r_vld [Depth];
    logic            en;
    sldiv_pkg::t_ctl ctl;
    logic [63:0]     q_lo, q_hi, r_lo, r_hi;

    assign en      = !r_vld[Depth-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Depth-1];

    always_comb begin
        ctl.bad  = i_data.cmd > 3'(sldiv_pkg::CMD_S64);
        ctl.sgn  = i_data.cmd[0];
        ctl.wsel = (i_data.cmd < 3'(sldiv_pkg::CMD_U32)) ? sldiv_pkg::WSEL_16 :
                   (i_data.cmd < 3'(sldiv_pkg::CMD_U64)) ? sldiv_pkg::WSEL_32 :
                   sldiv_pkg::WSEL_64;
    end

    sldiv_lane u_lane_lo (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_ctl(ctl),
        .i_x(i_data.dividend_lo), .i_y(i_data.divisor_lo), .o_q(q_lo), .o_r(r_lo)
    );
    sldiv_lane u_lane_hi (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_ctl(ctl),
        .i_x(i_data.dividend_hi), .i_y(i_data.divisor_hi), .o_q(q_hi), .o_r(r_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < Depth; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    assign o_data.quotient_lo  = q_lo;
    assign o_data.quotient_hi  = q_hi;
    assign o_data.remainder_lo = r_lo;
    assign o_data.remainder_hi = r_hi;

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while held");
    ap_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule
